FILE: rtl/dense_graph_shortest_path_macros.svh
`ifndef DENSE_GRAPH_SHORTEST_PATH_MACROS_SVH
`define DENSE_GRAPH_SHORTEST_PATH_MACROS_SVH

// same-cycle implication
`define DGSP_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DGSP_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/dgsp_pkg.sv
`timescale 1ns / 1ps

package dgsp_pkg;

    localparam int NODES            = 16;
    localparam int VW               = $clog2(NODES);
    localparam int CW               = $clog2(NODES + 1);
    localparam int AW               = 2 * VW;
    localparam int WW               = 10;
    localparam int DW               = 11;
    localparam int LIMIT            = 1000;
    localparam int MAX_OUT          = 16;
    localparam int KW               = $clog2(MAX_OUT);
    localparam int CFG_W            = 5;
    localparam int NODE_COUNT_RESET = 16;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_RUN  = 1'b1
    } action_t;

    typedef struct packed {
        logic          valid;
        logic [VW-1:0] start;
        logic [VW-1:0] finish;
        logic [CW-1:0] count;
    } run_req_t;

    typedef struct packed {
        logic          en;
        logic [AW-1:0] addr;
        logic [WW-1:0] data;
    } wr_req_t;

    typedef struct packed {
        logic [VW-1:0] vertex;
        logic [DW-1:0] length;
        logic          found;
        logic          last;
    } result_t;

endpackage

FILE: rtl/dense_graph_shortest_path.sv
// Load transaction: one per cycle, weight written into the matrix at the accepting edge.
// Run transaction: a round scans n distances through one shared compare, then relaxes n
// neighbors through the single matrix read port; at most n rounds, the last ends on the
// finish vertex (or with no reachable vertex left) without relaxing. Out of range or start
// equal to finish gives a single result; path results come one per cycle while not stalled.
// Not ready during a run. Sync active-low reset: control cleared, node_count 16.
`timescale 1ns / 1ps

module dense_graph_shortest_path import dgsp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_action,
    input  logic [3:0]       s_row_vertex,
    input  logic [3:0]       s_col_vertex,
    input  logic [9:0]       s_edge_weight_in,
    input  logic [3:0]       s_start_vertex,
    input  logic [3:0]       s_finish_vertex,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [3:0]       m_path_vertex,
    output logic [10:0]      m_path_length,
    output logic             m_found,
    output logic             m_last
);

    logic [CFG_W-1:0] node_count_reg;
    logic             accept;
    wr_req_t          wr;
    run_req_t         run;
    logic [AW-1:0]    rd_addr;
    logic [WW-1:0]    rd_data;
    result_t          res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_count_reg <= CFG_W'(NODE_COUNT_RESET);
        end else if (cfg_we) begin
            node_count_reg <= cfg_wdata;
        end
    end

    assign accept = s_valid && s_ready;

    assign wr.en   = accept && (s_action == ACT_LOAD);
    assign wr.addr = {VW'(s_row_vertex), VW'(s_col_vertex)};
    assign wr.data = WW'(s_edge_weight_in);

    assign run.valid  = accept && (s_action == ACT_RUN);
    assign run.start  = VW'(s_start_vertex);
    assign run.finish = VW'(s_finish_vertex);
    assign run.count  = (node_count_reg > CFG_W'(NODES)) ? CW'(NODES) : CW'(node_count_reg);

    dgsp_wmem u_wmem (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dgsp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .run_i       (run),
        .ready_o     (s_ready),
        .mem_rd_addr (rd_addr),
        .mem_rd_data (rd_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .res_o       (res)
    );

    assign m_path_vertex = 4'(res.vertex);
    assign m_path_length = 11'(res.length);
    assign m_found       = res.found;
    assign m_last        = res.last;

endmodule

FILE: rtl/dgsp_wmem.sv
`timescale 1ns / 1ps

module dgsp_wmem import dgsp_pkg::*; (
    input  logic          aclk,
    input  wr_req_t       wr,
    input  logic [AW-1:0] rd_addr,
    output logic [WW-1:0] rd_data
);

    logic [WW-1:0] mem [NODES*NODES];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/dgsp_core.sv
`timescale 1ns / 1ps

module dgsp_core import dgsp_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  run_req_t      run_i,
    output logic          ready_o,
    output logic [AW-1:0] mem_rd_addr,
    input  logic [WW-1:0] mem_rd_data,
    output logic          m_valid,
    input  logic          m_ready,
    output result_t       res_o
);

    typedef enum logic [2:0] {
        IDLE,
        PICK,
        RELAX,
        TRACE,
        SINGLE
    } state_t;

    state_t        state_reg, state_next;
    logic          visited_reg [NODES];
    logic          visited_next [NODES];
    logic [DW-1:0] dist_reg [NODES];
    logic [DW-1:0] dist_next [NODES];
    logic [VW-1:0] pred_reg [NODES];
    logic [VW-1:0] pred_next [NODES];
    logic          pv_reg [NODES];
    logic          pv_next [NODES];

    logic [VW-1:0] start_reg, start_next;
    logic [VW-1:0] finish_reg, finish_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [DW-1:0] least_reg, least_next;
    logic [VW-1:0] pick_reg, pick_next;
    logic          picked_reg, picked_next;
    logic [VW-1:0] u_reg, u_next;
    logic [DW-1:0] du_reg, du_next;
    logic [VW-1:0] jdx_reg, jdx_next;
    logic          jval_reg, jval_next;
    logic [VW-1:0] cur_reg, cur_next;
    logic [KW-1:0] k_reg, k_next;
    logic [DW-1:0] len_reg, len_next;
    logic          found_reg, found_next;
    logic          m_valid_reg, m_valid_next;
    result_t       res_reg, res_next;

    logic [VW-1:0] ix;
    logic          out_free;
    logic          take;
    logic          issue;
    logic          at_start;
    logic          trace_last;
    logic [WW-1:0] w;
    logic [DW-1:0] cand;
    logic          is_edge;

    assign ix          = idx_reg[VW-1:0];
    assign out_free    = !m_valid_reg || m_ready;
    assign ready_o     = (state_reg == IDLE);
    assign mem_rd_addr = {u_reg, ix};
    assign m_valid     = m_valid_reg;
    assign res_o       = res_reg;

    assign w       = mem_rd_data;
    assign cand    = du_reg + DW'(w);
    assign is_edge = (w != '0) && (DW'(w) < DW'(LIMIT));

    always_comb begin
        state_next   = state_reg;
        visited_next = visited_reg;
        dist_next    = dist_reg;
        pred_next    = pred_reg;
        pv_next      = pv_reg;
        start_next   = start_reg;
        finish_next  = finish_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        least_next   = least_reg;
        pick_next    = pick_reg;
        picked_next  = picked_reg;
        u_next       = u_reg;
        du_next      = du_reg;
        jdx_next     = ix;
        jval_next    = 1'b0;
        cur_next     = cur_reg;
        k_next       = k_reg;
        len_next     = len_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg && !m_ready;
        res_next     = res_reg;

        take       = !visited_reg[ix] && (dist_reg[ix] < least_reg);
        issue      = (idx_reg < count_reg);
        at_start   = (cur_reg == start_reg);
        trace_last = at_start || !pv_reg[cur_reg] || (k_reg == KW'(MAX_OUT - 1));

        case (state_reg)
            IDLE: begin
                if (run_i.valid) begin
                    start_next  = run_i.start;
                    finish_next = run_i.finish;
                    count_next  = run_i.count;
                    for (int i = 0; i < NODES; i++) begin
                        visited_next[i] = 1'b0;
                        dist_next[i]    = DW'(LIMIT);
                        pv_next[i]      = 1'b0;
                    end
                    dist_next[run_i.start] = '0;
                    idx_next    = '0;
                    least_next  = DW'(LIMIT);
                    picked_next = 1'b0;
                    if (CW'(run_i.start) >= run_i.count || CW'(run_i.finish) >= run_i.count) begin
                        cur_next   = '0;
                        found_next = 1'b0;
                        state_next = SINGLE;
                    end else if (run_i.start == run_i.finish) begin
                        cur_next   = run_i.finish;
                        found_next = 1'b1;
                        state_next = SINGLE;
                    end else begin
                        state_next = PICK;
                    end
                end
            end
            PICK: begin
                if (take) begin
                    least_next  = dist_reg[ix];
                    pick_next   = ix;
                    picked_next = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg + 1'b1 == count_reg) begin
                    idx_next = '0;
                    if (!picked_next) begin
                        cur_next   = '0;
                        found_next = 1'b0;
                        state_next = SINGLE;
                    end else begin
                        visited_next[pick_next] = 1'b1;
                        u_next  = pick_next;
                        du_next = least_next;
                        if (pick_next == finish_reg) begin
                            cur_next   = finish_reg;
                            len_next   = least_next;
                            k_next     = '0;
                            state_next = TRACE;
                        end else begin
                            state_next = RELAX;
                        end
                    end
                end
            end
            RELAX: begin
                if (issue) begin
                    idx_next  = idx_reg + 1'b1;
                    jval_next = 1'b1;
                end else begin
                    idx_next    = '0;
                    least_next  = DW'(LIMIT);
                    picked_next = 1'b0;
                    state_next  = PICK;
                end
            end
            TRACE: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    res_next.vertex = cur_reg;
                    res_next.length = len_reg;
                    res_next.found  = 1'b1;
                    res_next.last   = trace_last;
                    if (trace_last) begin
                        state_next = IDLE;
                    end else begin
                        cur_next = pred_reg[cur_reg];
                        k_next   = k_reg + 1'b1;
                    end
                end
            end
            SINGLE: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    res_next.vertex = cur_reg;
                    res_next.length = '0;
                    res_next.found  = found_reg;
                    res_next.last   = 1'b1;
                    state_next      = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase

        // relax one neighbor in the cycle after its matrix read is issued
        if (jval_reg && !visited_reg[jdx_reg] && is_edge && (dist_reg[jdx_reg] > cand)) begin
            dist_next[jdx_reg] = cand;
            pred_next[jdx_reg] = u_reg;
            pv_next[jdx_reg]   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
            jval_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            jval_reg    <= jval_next;
        end
        visited_reg <= visited_next;
        dist_reg    <= dist_next;
        pred_reg    <= pred_next;
        pv_reg      <= pv_next;
        start_reg   <= start_next;
        finish_reg  <= finish_next;
        count_reg   <= count_next;
        idx_reg     <= idx_next;
        least_reg   <= least_next;
        pick_reg    <= pick_next;
        picked_reg  <= picked_next;
        u_reg       <= u_next;
        du_reg      <= du_next;
        jdx_reg     <= jdx_next;
        cur_reg     <= cur_next;
        k_reg       <= k_next;
        len_reg     <= len_next;
        found_reg   <= found_next;
        res_reg     <= res_next;
    end

endmodule

FILE: rtl/dgsp_checker.sv
`timescale 1ns / 1ps
`include "dense_graph_shortest_path_macros.svh"

module dgsp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_action,
    input logic        m_valid,
    input logic        m_ready,
    input logic [3:0]  m_path_vertex,
    input logic [10:0] m_path_length,
    input logic        m_found,
    input logic        m_last
);

    `DGSP_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_path_vertex) && $stable(m_path_length) && $stable(m_found) && $stable(m_last), "result changed while stalled")
    `DGSP_ASSERT_IMP(a_notfound_form, aclk, aresetn, m_valid && !m_found, m_last && m_path_vertex == 4'd0 && m_path_length == 11'd0, "malformed not-found transaction")
    `DGSP_ASSERT_NXT(a_run_busy, aclk, aresetn, s_valid && s_ready && s_action, !s_ready, "ready after run transaction")
    `DGSP_ASSERT_NXT(a_path_burst, aclk, aresetn, m_valid && m_ready && !m_last, m_valid, "gap inside path transactions")

endmodule

bind dense_graph_shortest_path dgsp_checker u_dgsp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_action      (s_action),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_path_vertex (m_path_vertex),
    .m_path_length (m_path_length),
    .m_found       (m_found),
    .m_last        (m_last)
);
